>>> src/eardr_pkg.sv
package eardr_pkg;

  // Default coordinate width of one landmark axis
  localparam int unsigned COORD_BITS_DEF = 12;

  // Input item layout: twelve packed points, left eye first
  localparam int unsigned NUM_POINTS = 12;
  localparam int unsigned POINT_W    = 24;
  localparam int unsigned IN_W       = NUM_POINTS * POINT_W;

  // Result packing: ear_avg, alarm, closed_count, padded to whole bytes
  localparam int unsigned EAR_W = 16;
  localparam int unsigned RUN_W = 8;
  localparam int unsigned OUT_W = 32;

  // Ratio division: quotient bits and the Q1.15 scaling shift of (A+B)/(2C)
  localparam int unsigned QUOT_W      = 16;
  localparam int unsigned RATIO_SHIFT = 14;

  localparam logic [EAR_W-1:0] RATIO_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_MAX   = '1;

  localparam logic [EAR_W-1:0] THR_RESET = 16'd8192;
  localparam logic [RUN_W-1:0] LIM_RESET = 8'd15;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CLOSE_LEVEL      = 2'd0;
  localparam cfg_idx_t CFG_CLOSED_RUN_LIMIT = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Point slots in working order: A pair (p1,p5), B pair (p2,p4), C pair (p0,p3), per eye
  localparam int unsigned SLOT_SRC [NUM_POINTS] = '{1, 5, 2, 4, 0, 3, 7, 11, 8, 10, 6, 9};

  localparam logic EYE_LEFT  = 1'b0;
  localparam logic EYE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIST_A,
    DIST_B,
    DIST_C
  } dist_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQST,
    ST_SQRT,
    ST_RATIO,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

>>> src/eardr_sqrt.sv
module eardr_sqrt #(
  parameter int unsigned COORD_BITS = eardr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2*COORD_BITS+17:0] radicand_i,
  output logic                    done_o,
  output logic [COORD_BITS+8:0]   root_o
);
  import eardr_pkg::*;

  localparam int unsigned DW    = COORD_BITS + 9;
  localparam int unsigned VW    = 2 * DW;
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [VW-1:0] BIT_INIT = {2'b01, {(VW-2){1'b0}}};

  logic [VW-1:0]    v_q, v_d;
  logic [VW-1:0]    r_q, r_d;
  logic [VW-1:0]    bit_q, bit_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [VW:0]      trial;

  // One result bit per step
  always_comb begin
    trial = {1'b0, r_q} + {1'b0, bit_q};
    if ({1'b0, v_q} >= trial) begin
      v_d = v_q - trial[VW-1:0];
      r_d = (r_q >> 1) + bit_q;
    end else begin
      v_d = v_q;
      r_d = r_q >> 1;
    end
    bit_d = bit_q >> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= BIT_INIT;
    end else if (busy_q) begin
      v_q   <= v_d;
      r_q   <= r_d;
      bit_q <= bit_d;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[DW-1:0];

endmodule

>>> src/eardr_div.sv
module eardr_div #(
  parameter int unsigned COORD_BITS = eardr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COORD_BITS+9:0]         dividend_i,
  input  logic [COORD_BITS+8:0]         divisor_i,
  output logic                          done_o,
  output logic [eardr_pkg::QUOT_W-1:0]  quot_o
);
  import eardr_pkg::*;

  localparam int unsigned DW    = COORD_BITS + 9;
  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);
  localparam int unsigned LOW_W = QUOT_W - RATIO_SHIFT;

  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     div_q;
  logic [QUOT_W-1:0] num_q;
  logic [QUOT_W-1:0] quot_q;
  logic              qbit;
  logic [DW:0]       trial;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  // Restoring step: bring down one dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[QUOT_W-1]};
    qbit  = (trial >= {1'b0, div_q});
    if (qbit) begin
      rem_d = DW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // Upper part of (dividend << RATIO_SHIFT) is known to be below the divisor
      rem_q  <= DW'(dividend_i[DW:LOW_W]);
      num_q  <= {dividend_i[LOW_W-1:0], {RATIO_SHIFT{1'b0}}};
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/eye_aspect_ratio_drowsiness_core.sv
// Eye aspect ratio drowsiness core. One transaction on the slave stream is one face: six
// landmark points per eye. For each eye the core forms the distances A=|p1-p5|, B=|p2-p4|
// and C=|p0-p3| in Q.8, the ratio (A+B)/(2C) in unsigned Q1.15 (saturated at 65535, also
// when C is zero), averages the two eyes and keeps a saturating run count of faces whose
// average lies below the closed-eye level register. Alarm is set when a closed face brings
// the run to closed_run_limit or beyond. One result transaction leaves per face. The
// bit-serial square root dominates (COORD_BITS+9 steps per distance, six distances),
// followed by a 16-step restoring divider per eye, skipped for an eye whose ratio
// saturates. The slave side is ready only between faces; a finished result waits in the
// output register, so the next face is taken while the previous result is still
// unclaimed. Configuration writes are always taken.
module eye_aspect_ratio_drowsiness_core #(
  parameter int unsigned COORD_BITS = eardr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Face input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, from bit 0 up: left_p0..left_p5, right_p0..right_p5, 24 bits each
  input  logic [eardr_pkg::IN_W-1:0]       s_axis_tdata,
  // Result output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, from bit 0 up: ear_avg[15:0], alarm[16], closed_count[24:17], zeros[31:25]
  output logic [eardr_pkg::OUT_W-1:0]      m_axis_tdata,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  eardr_pkg::cfg_idx_t              cfg_index_i,
  input  logic [eardr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import eardr_pkg::*;

  localparam int unsigned PW   = 2 * COORD_BITS;
  localparam int unsigned D2_W = 2 * COORD_BITS + 1;
  localparam int unsigned DW   = COORD_BITS + 9;

  state_e state_q, state_d;

  // Point slots, held in working order; the active pair always sits in slots 0 and 1
  logic [PW-1:0]         pts_q [NUM_POINTS];
  logic                  eye_q;
  dist_e                 dist_q;
  logic [D2_W-1:0]       d2_q;
  logic [DW-1:0]         a_q, b_q, c_q;
  logic [EAR_W-1:0]      ratio_l_q, ratio_r_q;
  logic [EAR_W-1:0]      thr_q;
  logic [RUN_W-1:0]      lim_q;
  logic [RUN_W-1:0]      run_q;
  logic                  out_valid_q;
  logic [EAR_W-1:0]      out_avg_q;
  logic                  out_alarm_q;
  logic [RUN_W-1:0]      out_run_q;

  // Control from the sequencer
  logic                  ld_pts;
  logic                  sqrt_start;
  logic                  dist_adv;
  logic                  div_start;
  logic                  ratio_wr;
  logic                  eye_adv;
  logic                  fin_load;

  // Datapath
  logic [COORD_BITS-1:0] xa, xb, ya, yb, dx, dy, mul_op;
  logic [PW-1:0]         mul_prod;
  logic                  sqrt_done, div_done;
  logic [DW-1:0]         root;
  logic [QUOT_W-1:0]     quot;
  logic [DW:0]           sum_ab;
  logic                  sat;
  logic [EAR_W-1:0]      ratio_val;
  logic [EAR_W:0]        avg_sum;
  logic [EAR_W-1:0]      avg;
  logic                  closed;
  logic [RUN_W-1:0]      run_next;

  // ---------------------------------------------------------------------------------------
  // Shared squarer: dx squared, then dy squared accumulated into d2
  // ---------------------------------------------------------------------------------------
  assign xa = pts_q[0][PW-1:COORD_BITS];
  assign xb = pts_q[1][PW-1:COORD_BITS];
  assign ya = pts_q[0][COORD_BITS-1:0];
  assign yb = pts_q[1][COORD_BITS-1:0];
  assign dx = (xa >= xb) ? (xa - xb) : (xb - xa);
  assign dy = (ya >= yb) ? (ya - yb) : (yb - ya);

  assign mul_op   = (state_q == ST_SQX) ? dx : dy;
  assign mul_prod = {{COORD_BITS{1'b0}}, mul_op} * {{COORD_BITS{1'b0}}, mul_op};

  // Distance in Q.8 is the root of d2 scaled by 2^16
  eardr_sqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({1'b0, d2_q, 16'h0000}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Ratio (A+B)*2^14/C exceeds 65535 exactly when A+B >= 4C; that covers C of zero too
  assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
  assign sat    = ({1'b0, sum_ab} >= {c_q, 2'b00});

  eardr_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_ab),
    .divisor_i  (c_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign ratio_val = (state_q == ST_DIV) ? quot : RATIO_MAX;

  // Average, closed decision and run update
  assign avg_sum  = {1'b0, ratio_l_q} + {1'b0, ratio_r_q};
  assign avg      = avg_sum[EAR_W:1];
  assign closed   = (avg < thr_q);
  always_comb begin
    if (!closed) begin
      run_next = '0;
    end else if (run_q == RUN_MAX) begin
      run_next = run_q;
    end else begin
      run_next = run_q + RUN_W'(1);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_SQX;
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQST;
      ST_SQST: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = (dist_q == DIST_C) ? ST_RATIO : ST_SQX;
        end
      end
      ST_RATIO: begin
        if (!sat) begin
          state_d = ST_DIV;
        end else begin
          state_d = (eye_q == EYE_RIGHT) ? ST_FIN : ST_SQX;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = (eye_q == EYE_RIGHT) ? ST_FIN : ST_SQX;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------------------------
  always_comb begin
    ld_pts     = 1'b0;
    sqrt_start = 1'b0;
    dist_adv   = 1'b0;
    div_start  = 1'b0;
    ratio_wr   = 1'b0;
    fin_load   = 1'b0;
    case (state_q)
      ST_IDLE:  ld_pts     = s_axis_tvalid;
      ST_SQST:  sqrt_start = 1'b1;
      ST_SQRT:  dist_adv   = sqrt_done;
      ST_RATIO: begin
        div_start = !sat;
        ratio_wr  = sat;
      end
      ST_DIV:   ratio_wr   = div_done;
      ST_FIN:   fin_load   = !out_valid_q || m_axis_tready;
      default: begin
      end
    endcase
  end

  assign eye_adv = ratio_wr && (eye_q == EYE_LEFT);

  // ---------------------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eye_q       <= EYE_LEFT;
      dist_q      <= DIST_A;
      run_q       <= '0;
      thr_q       <= THR_RESET;
      lim_q       <= LIM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (ld_pts) begin
        eye_q <= EYE_LEFT;
      end else if (eye_adv) begin
        eye_q <= EYE_RIGHT;
      end

      if (ld_pts || eye_adv) begin
        dist_q <= DIST_A;
      end else if (dist_adv) begin
        case (dist_q)
          DIST_A:  dist_q <= DIST_B;
          DIST_B:  dist_q <= DIST_C;
          default: dist_q <= DIST_A;
        endcase
      end

      // Hold the result until taken; a fresh load wins over the hand-off
      if (fin_load) begin
        out_valid_q <= 1'b1;
        run_q       <= run_next;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CLOSE_LEVEL:      thr_q <= cfg_data_i[EAR_W-1:0];
          CFG_CLOSED_RUN_LIMIT: lim_q <= cfg_data_i[RUN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // Capture the points in working order; advance by one pair per finished distance
    if (ld_pts) begin
      for (int unsigned k = 0; k < NUM_POINTS; k++) begin
        pts_q[k] <= PW'(s_axis_tdata[SLOT_SRC[k]*POINT_W +: POINT_W]);
      end
    end else if (dist_adv) begin
      for (int unsigned k = 0; k < NUM_POINTS - 2; k++) begin
        pts_q[k] <= pts_q[k+2];
      end
    end

    case (state_q)
      ST_SQX:  d2_q <= {1'b0, mul_prod};
      ST_SQY:  d2_q <= d2_q + {1'b0, mul_prod};
      default: begin
      end
    endcase

    if (dist_adv) begin
      case (dist_q)
        DIST_A:  a_q <= root;
        DIST_B:  b_q <= root;
        default: c_q <= root;
      endcase
    end

    if (ratio_wr) begin
      if (eye_q == EYE_LEFT) begin
        ratio_l_q <= ratio_val;
      end else begin
        ratio_r_q <= ratio_val;
      end
    end

    if (fin_load) begin
      out_avg_q   <= avg;
      out_alarm_q <= closed && (run_next >= lim_q);
      out_run_q   <= run_next;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-EAR_W-1-RUN_W){1'b0}}, out_run_q, out_alarm_q, out_avg_q};
  assign cfg_ready_o   = 1'b1;

endmodule

>>> sim/eardr_checker.sv
module eardr_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             face_valid_i,
  input  logic                             face_ready_i,
  input  logic [eardr_pkg::IN_W-1:0]       face_data_i,
  input  logic                             result_valid_i,
  input  logic                             result_ready_i,
  input  logic [eardr_pkg::OUT_W-1:0]      result_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  eardr_pkg::cfg_idx_t              cfg_index_i,
  input  logic [eardr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      mismatches_o,
  output int unsigned                      awaited_o,
  output int unsigned                      checked_o,
  output int unsigned                      closed_o,
  output int unsigned                      alarms_o,
  output int unsigned                      longest_run_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import eardr_pkg::*;

  localparam int unsigned CB    = COORD_BITS_DEF;
  localparam int unsigned EYE_W = IN_W / 2;

  // Field order from the top bit down, so that ear sits at bit 0
  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic             alarm;
    logic [EAR_W-1:0] ear;
  } face_result_t;

  localparam int unsigned RES_W = $bits(face_result_t);

  logic [EAR_W-1:0] thr_q;
  logic [RUN_W-1:0] lim_q;
  logic [RUN_W-1:0] run_q;
  face_result_t     awaited_results [$];

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Distance between two packed points in Q.8
  function automatic longint unsigned span_q8(input logic [POINT_W-1:0] p,
                                              input logic [POINT_W-1:0] q);
    longint unsigned px, py, qx, qy, dx, dy;
    px = p[2*CB-1:CB];
    py = p[CB-1:0];
    qx = q[2*CB-1:CB];
    qy = q[CB-1:0];
    dx = (px > qx) ? px - qx : qx - px;
    dy = (py > qy) ? py - qy : qy - py;
    return root_floor((dx * dx + dy * dy) << 16);
  endfunction

  // (A+B)/(2C) in Q1.15, saturated; a zero corner span saturates too
  function automatic logic [EAR_W-1:0] eye_ear(input logic [EYE_W-1:0] eye);
    logic [POINT_W-1:0] p [6];
    longint unsigned    lid_a, lid_b, corner, q;
    for (int k = 0; k < 6; k++) p[k] = eye[k*POINT_W +: POINT_W];
    lid_a  = span_q8(p[1], p[5]);
    lid_b  = span_q8(p[2], p[4]);
    corner = span_q8(p[0], p[3]);
    if (corner == 0) return RATIO_MAX;
    q = ((lid_a + lid_b) << RATIO_SHIFT) / corner;
    return (q > RATIO_MAX) ? RATIO_MAX : q[EAR_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    face_result_t     got, want;
    logic [EAR_W:0]   both;
    logic [EAR_W-1:0] ear;
    if (!rst_ni) begin
      thr_q = THR_RESET;
      lim_q = LIM_RESET;
      run_q = '0;
      awaited_results.delete();
      awaited_o = 0;
    end else begin
      // results before faces: nothing accepted at this edge can already be out
      if (result_valid_i && result_ready_i) begin
        got = result_data_i[RES_W-1:0];
        if (awaited_results.size() == 0) begin
          mismatches_o++;
          $error("result with no face outstanding: tdata %h", result_data_i);
        end else begin
          want = awaited_results.pop_front();
          checked_o++;
          if (got.ear !== want.ear) begin
            mismatches_o++;
            $error("ear_avg mismatch: expected %0d, actual %0d", want.ear, got.ear);
          end
          if (got.alarm !== want.alarm) begin
            mismatches_o++;
            $error("alarm mismatch: expected %0d, actual %0d", want.alarm, got.alarm);
          end
          if (got.run !== want.run) begin
            mismatches_o++;
            $error("closed_count mismatch: expected %0d, actual %0d", want.run, got.run);
          end
          if (result_data_i[OUT_W-1:RES_W] !== '0) begin
            mismatches_o++;
            $error("padding mismatch: expected 0, actual %0h", result_data_i[OUT_W-1:RES_W]);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CLOSE_LEVEL:      thr_q = cfg_data_i[EAR_W-1:0];
          CFG_CLOSED_RUN_LIMIT: lim_q = cfg_data_i[RUN_W-1:0];
          default: ;
        endcase
      end
      if (face_valid_i && face_ready_i) begin
        both = eye_ear(face_data_i[EYE_W-1:0]) + eye_ear(face_data_i[IN_W-1:EYE_W]);
        ear  = both[EAR_W:1];
        want.ear   = ear;
        want.alarm = 1'b0;
        if (ear < thr_q) begin
          if (run_q != RUN_MAX) run_q++;
          want.alarm = (run_q >= lim_q);
          closed_o++;
          if (want.alarm) alarms_o++;
        end else begin
          run_q = '0;
        end
        want.run = run_q;
        if (run_q > longest_run_o) longest_run_o = run_q;
        awaited_results.push_back(want);
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eardr_pkg::*;

  localparam int unsigned RANDOM_FACES = 1800;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned MAX_GAP      = 14;
  // long enough for two whole faces to fill the core behind a stalled output
  localparam int unsigned HOLD_OFF     = 2500;
  // idle time after the final drain, longer than one face at the default coordinate width
  localparam int unsigned SETTLE       = 400;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SAT_STREAK   = 300;
  localparam int unsigned CB           = COORD_BITS_DEF;
  localparam int unsigned AXIS_MAX     = (1 << CB) - 1;

  // Phases with a fixed purpose; the rest use random settings
  localparam int unsigned PH_SATURATE  = 1;
  localparam int unsigned PH_NONE_SHUT = 2;
  localparam int unsigned PH_ZERO_LIM  = 3;
  localparam int unsigned PH_PRESSURE  = 4;
  localparam int unsigned PH_PAUSE     = 5;
  localparam int unsigned PH_WILD      = 7;

  // Register indexes the core does not decode
  localparam cfg_idx_t CFG_UNUSED_LO = 2'd2;
  localparam cfg_idx_t CFG_UNUSED_HI = 2'd3;

  typedef logic [IN_W-1:0]    face_t;
  typedef logic [IN_W/2-1:0]  eye_t;
  typedef logic [POINT_W-1:0] point_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  face_t                 s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i   = CFG_CLOSE_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int unsigned mismatches, awaited, checked, closed_faces, alarms, longest_run;
  int unsigned cycles         = 0;
  int unsigned faces_sent     = 0;
  int unsigned directed_faces = 0;
  int unsigned reg_writes     = 0;
  int unsigned settings_used  = 0;
  int unsigned hold_cycles    = 0;
  // no idling on either side while set
  bit          calm           = 1'b0;

  eye_aspect_ratio_drowsiness_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  eardr_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .face_valid_i   (s_axis_tvalid),
    .face_ready_i   (s_axis_tready),
    .face_data_i    (s_axis_tdata),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatches_o   (mismatches),
    .awaited_o      (awaited),
    .checked_o      (checked),
    .closed_o       (closed_faces),
    .alarms_o       (alarms),
    .longest_run_o  (longest_run)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("no progress after %0d cycles, %0d results outstanding", cycles, awaited);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic point_t pt(input int unsigned x, input int unsigned y);
    return {x[CB-1:0], y[CB-1:0]};
  endfunction

  function automatic eye_t eye6(input point_t p0, input point_t p1, input point_t p2,
                                input point_t p3, input point_t p4, input point_t p5);
    return {p5, p4, p3, p2, p1, p0};
  endfunction

  // Plausible eye: corners level, lids above and below; shut lids sit within w/8
  function automatic eye_t make_eye(input bit shut);
    int unsigned w, h1, h2, hm, cx, cy, lx, rx;
    w  = $urandom_range(2, 600);
    h1 = shut ? $urandom_range(0, w / 8) : $urandom_range(w / 3, w);
    h2 = shut ? $urandom_range(0, w / 8) : $urandom_range(w / 3, w);
    hm = (h1 > h2) ? h1 : h2;
    cx = $urandom_range(w, AXIS_MAX - w);
    cy = $urandom_range(hm, AXIS_MAX - hm);
    lx = cx - w / 3;
    rx = cx + w / 3;
    return eye6(pt(cx - w, cy), pt(lx, cy - h1), pt(rx, cy - h2),
                pt(cx + w, cy), pt(rx, cy + h2), pt(lx, cy + h1));
  endfunction

  // Now and then the two eyes disagree
  function automatic face_t make_face(input bit shut);
    bit odd;
    odd = ($urandom_range(0, 4) == 0);
    return {make_eye(shut ^ odd), make_eye(shut)};
  endfunction

  function automatic face_t noise_face();
    face_t f;
    for (int k = 0; k < IN_W; k += 32) f[k +: 32] = $urandom;
    return f;
  endfunction

  // Offer one face and hold it until the transaction completes. Valid stays
  // high afterwards so that a zero gap gives back-to-back transactions.
  task automatic send_face(input face_t f);
    int unsigned gap;
    gap = pause_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    faces_sent++;
  endtask

  // Drop valid and wait until every face has produced its result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    @(posedge clk_i);
  endtask

  // Valid stays high between back-to-back writes; the caller drops it
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  // Only ever called with the core idle, i.e. straight after wait_drained
  task automatic configure(input logic [EAR_W-1:0] thr, input logic [CFG_DATA_W-1:0] lim);
    write_reg(CFG_CLOSE_LEVEL, thr);
    if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_CLOSED_RUN_LIMIT, lim);
    if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED_HI, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Result side: random stalls, plus one long hold-off when asked for
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = pause_len();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    eye_t                  wide, tall, flat, dot;
    logic [EAR_W-1:0]      thr;
    logic [CFG_DATA_W-1:0] lim;
    int unsigned           target, streak;

    // Wide: all three spans equal, ratio exactly 1.0. Tall: lids far apart,
    // corners one pixel apart, so the ratio saturates. Flat: lids touch.
    // Dot: every point the same, zero corner span.
    wide = eye6(pt(0, 0), pt(0, 0), pt(0, AXIS_MAX),
                pt(AXIS_MAX, AXIS_MAX), pt(AXIS_MAX, 0), pt(AXIS_MAX, AXIS_MAX));
    tall = eye6(pt(2000, 2000), pt(0, 0), pt(AXIS_MAX, 0),
                pt(2001, 2000), pt(0, AXIS_MAX), pt(AXIS_MAX, AXIS_MAX));
    flat = eye6(pt(100, 500), pt(366, 500), pt(633, 500),
                pt(900, 500), pt(633, 500), pt(366, 500));
    dot  = eye6(pt(1234, 3210), pt(1234, 3210), pt(1234, 3210),
                pt(1234, 3210), pt(1234, 3210), pt(1234, 3210));

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed faces under the reset settings
    send_face('0);
    send_face('1);
    send_face({wide, wide});
    send_face({tall, tall});
    send_face({dot, flat});
    send_face({flat, flat});
    send_face({flat, flat});
    send_face({flat, wide});

    // Short limit: alarm from the third closed face on, cleared by an open one
    wait_drained();
    configure(16'd20000, 16'hA503);
    repeat (5) send_face({flat, flat});
    send_face({wide, wide});

    // Average equal to the threshold counts open; a zero limit alarms at once
    wait_drained();
    configure(16'd32768, 16'h5A00);
    send_face({wide, wide});
    send_face({flat, flat});
    wait_drained();
    configure(16'd32769, 16'hFF00);
    send_face({wide, wide});
    send_face({flat, tall});
    directed_faces = faces_sent;

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        PH_SATURATE: begin
          thr = '1;
          lim = {8'($urandom), 8'hFF};
        end
        PH_NONE_SHUT: begin
          thr = '0;
          lim = 16'd1;
        end
        PH_ZERO_LIM: begin
          thr = THR_RESET;
          lim = {8'($urandom), 8'h00};
        end
        PH_WILD: begin
          thr = EAR_W'($urandom_range(0, 65535));
          lim = {8'($urandom), 8'($urandom_range(1, 255))};
        end
        default: begin
          thr = EAR_W'($urandom_range(5000, 11000));
          lim = {8'($urandom), 8'($urandom_range(1, 30))};
        end
      endcase
      wait_drained();
      configure(thr, lim);
      if (ph == PH_PRESSURE) hold_cycles = HOLD_OFF;
      // run long enough to pin the counter at its ceiling
      if (ph == PH_SATURATE) repeat (SAT_STREAK) send_face(make_face(1'b1));
      target = directed_faces + (ph + 1) * RANDOM_FACES / NUM_PHASES;
      while (faces_sent < target) begin
        calm = ($urandom_range(0, 3) == 0);
        if (ph == PH_PAUSE && faces_sent >= target - RANDOM_FACES / (2 * NUM_PHASES)
            && $urandom_range(0, 3) == 0)
          wait_drained();
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 3)) send_face(noise_face());
        end else begin
          // a closed run of random length, then the eyes open again
          streak = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(0, 20);
          repeat (streak) send_face(make_face(1'b1));
          repeat ($urandom_range(1, 3)) send_face(make_face(1'b0));
        end
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d faces sent (%0d directed), %0d register writes over %0d settings",
             faces_sent, directed_faces, reg_writes, settings_used);
    $display("%0d results checked: %0d closed, %0d with alarm, longest closed run %0d",
             checked, closed_faces, alarms, longest_run);
    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
